### rtl/core/ppt_pkg.sv
// Shared types and constants of the probable prime tester.
// Holds the result codes, multiplier operand selects and the
// controller/datapath command and status structs. No dependencies.
package ppt_pkg;

    localparam logic [2:0] REJ_NONE   = 3'd0;
    localparam logic [2:0] REJ_LOW    = 3'd1;
    localparam logic [2:0] REJ_FERMAT2 = 3'd2;
    localparam logic [2:0] REJ_FERMAT3 = 3'd3;
    localparam logic [2:0] REJ_STRONG = 3'd4;

    localparam logic [1:0] MSEL_ACC_SQ  = 2'd0;
    localparam logic [1:0] MSEL_SQ_SQ   = 2'd1;
    localparam logic [1:0] MSEL_ACC_ACC = 2'd2;
    localparam logic [1:0] MSEL_ONE_W   = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       acc_one;
        logic       acc_from_r;
        logic       sq_set2;
        logic       sq_set3;
        logic       sq_from_r;
        logic       e_load_nm1;
        logic       e_load_d;
        logic       e_shift;
        logic       d_init;
        logic       d_shift;
        logic       s_dec;
    } ppt_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_2or3;
        logic n_even;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic acc_nm1;
        logic mul_busy;
        logic r_zero;
        logic r_nm1;
        logic d_odd;
        logic s_le1;
    } ppt_sts_t;

endpackage

### rtl/core/ppt_dp.sv
// Datapath of the probable prime tester: operand registers and a
// bit-serial interleaved modular multiplier. Depends on ppt_pkg.
module ppt_dp
    import ppt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] candidate,
    input  logic [WIDTH-1:0] witness,
    input  ppt_cmd_t         cmd,
    output ppt_sts_t         sts
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] n_reg, w_reg, acc_reg, sq_reg, e_reg, d_reg, r_reg, mx_reg, my_reg;
    logic [CW-1:0]    s_reg, cnt_reg;
    logic             busy_reg, phase_reg;
    logic [WIDTH-1:0] nm1;
    logic [WIDTH:0]   sum, diff;
    logic [WIDTH-1:0] r_next;

    assign nm1 = n_reg - {{(WIDTH-1){1'b0}}, 1'b1};

    // one add and one compare-subtract per cycle: double on phase 0, add on phase 1
    always_comb
    begin
        if (phase_reg)
            sum = {1'b0, r_reg} + (my_reg[WIDTH-1] ? {1'b0, mx_reg} : '0);
        else
            sum = {1'b0, r_reg} + {1'b0, r_reg};
        diff   = sum - {1'b0, n_reg};
        r_next = diff[WIDTH] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (cmd.mul_start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg   <= CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            n_reg <= candidate;
            w_reg <= witness;
        end
        if (cmd.mul_start)
        begin
            r_reg <= '0;
            unique case (cmd.mul_sel)
                MSEL_ACC_SQ:
                begin
                    mx_reg <= acc_reg;
                    my_reg <= sq_reg;
                end
                MSEL_SQ_SQ:
                begin
                    mx_reg <= sq_reg;
                    my_reg <= sq_reg;
                end
                MSEL_ACC_ACC:
                begin
                    mx_reg <= acc_reg;
                    my_reg <= acc_reg;
                end
                default:
                begin
                    mx_reg <= {{(WIDTH-1){1'b0}}, 1'b1};
                    my_reg <= w_reg;
                end
            endcase
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            if (phase_reg)
                my_reg <= {my_reg[WIDTH-2:0], 1'b0};
        end
        if (cmd.acc_one)
            acc_reg <= {{(WIDTH-1){1'b0}}, 1'b1};
        else if (cmd.acc_from_r)
            acc_reg <= r_reg;
        if (cmd.sq_set2)
            sq_reg <= WIDTH'(2);
        else if (cmd.sq_set3)
            sq_reg <= WIDTH'(3);
        else if (cmd.sq_from_r)
            sq_reg <= r_reg;
        if (cmd.e_load_nm1)
            e_reg <= nm1;
        else if (cmd.e_load_d)
            e_reg <= d_reg;
        else if (cmd.e_shift)
            e_reg <= {1'b0, e_reg[WIDTH-1:1]};
        if (cmd.d_init)
        begin
            d_reg <= nm1;
            s_reg <= '0;
        end
        else if (cmd.d_shift)
        begin
            d_reg <= {1'b0, d_reg[WIDTH-1:1]};
            s_reg <= s_reg + 1'b1;
        end
        else if (cmd.s_dec)
            s_reg <= s_reg - 1'b1;
    end

    always_comb
    begin
        sts.n_lt2    = (n_reg[WIDTH-1:1] == '0);
        sts.n_2or3   = (n_reg == WIDTH'(2)) || (n_reg == WIDTH'(3));
        sts.n_even   = ~n_reg[0];
        sts.e_zero   = (e_reg == '0);
        sts.e_lsb    = e_reg[0];
        sts.acc_one  = (acc_reg == WIDTH'(1));
        sts.acc_nm1  = (acc_reg == nm1);
        sts.mul_busy = busy_reg;
        sts.r_zero   = (r_reg == '0);
        sts.r_nm1    = (r_reg == nm1);
        sts.d_odd    = d_reg[0];
        sts.s_le1    = (s_reg <= CW'(1));
    end

endmodule

### rtl/core/ppt_ctrl.sv
// Controller of the probable prime tester: sequences the Fermat and
// strong rounds and holds the result beat. Depends on ppt_pkg.
module ppt_ctrl
    import ppt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     out_prime,
    output logic [2:0] out_code,
    input  ppt_sts_t sts,
    output ppt_cmd_t cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_PINIT  = 4'd2;
    localparam logic [3:0] S_PBIT   = 4'd3;
    localparam logic [3:0] S_PWA    = 4'd4;
    localparam logic [3:0] S_PMS    = 4'd5;
    localparam logic [3:0] S_PWS    = 4'd6;
    localparam logic [3:0] S_PEND   = 4'd7;
    localparam logic [3:0] S_WRED   = 4'd8;
    localparam logic [3:0] S_DS     = 4'd9;
    localparam logic [3:0] S_SQ     = 4'd10;
    localparam logic [3:0] S_SQW    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [1:0] PH_F2 = 2'd0;
    localparam logic [1:0] PH_F3 = 2'd1;
    localparam logic [1:0] PH_SR = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] ph_reg, ph_next;
    logic [2:0] code_reg, code_next;
    logic       ov_reg, ov_next, op_reg, op_next;
    logic [2:0] oc_reg, oc_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_prime = op_reg;
    assign out_code  = oc_reg;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        code_next  = code_reg;
        ov_next    = ov_reg && !out_ready;
        op_next    = op_reg;
        oc_next    = oc_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ph_next = PH_F2;
                if (sts.n_lt2)
                begin
                    code_next  = REJ_LOW;
                    state_next = S_OUT;
                end
                else if (sts.n_2or3)
                begin
                    code_next  = REJ_NONE;
                    state_next = S_OUT;
                end
                else if (sts.n_even)
                begin
                    code_next  = REJ_FERMAT2;
                    state_next = S_OUT;
                end
                else
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.acc_one    = 1'b1;
                cmd.sq_set2    = (ph_reg == PH_F2);
                cmd.sq_set3    = (ph_reg == PH_F3);
                cmd.e_load_nm1 = (ph_reg != PH_SR);
                cmd.e_load_d   = (ph_reg == PH_SR);
                state_next     = S_PBIT;
            end
            S_PBIT:
            begin
                if (sts.e_zero)
                    state_next = S_PEND;
                else if (sts.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_ACC_SQ;
                    state_next    = S_PWA;
                end
                else
                    state_next = S_PMS;
            end
            S_PWA:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.acc_from_r = 1'b1;
                    state_next     = S_PMS;
                end
            end
            S_PMS:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_SQ_SQ;
                state_next    = S_PWS;
            end
            S_PWS:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.sq_from_r = 1'b1;
                    cmd.e_shift   = 1'b1;
                    state_next    = S_PBIT;
                end
            end
            S_PEND:
            begin
                unique case (ph_reg)
                    PH_F2:
                    begin
                        if (!sts.acc_one)
                        begin
                            code_next  = REJ_FERMAT2;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            ph_next    = PH_F3;
                            state_next = S_PINIT;
                        end
                    end
                    PH_F3:
                    begin
                        if (!sts.acc_one)
                        begin
                            code_next  = REJ_FERMAT3;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            // reduce the witness modulo the candidate
                            cmd.mul_start = 1'b1;
                            cmd.mul_sel   = MSEL_ONE_W;
                            state_next    = S_WRED;
                        end
                    end
                    default:
                    begin
                        if (sts.acc_one || sts.acc_nm1)
                        begin
                            code_next  = REJ_NONE;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_SQ;
                    end
                endcase
            end
            S_WRED:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.sq_from_r = 1'b1;
                    cmd.d_init    = 1'b1;
                    if (sts.r_zero)
                    begin
                        code_next  = REJ_NONE;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_DS;
                end
            end
            S_DS:
            begin
                if (sts.d_odd)
                begin
                    ph_next    = PH_SR;
                    state_next = S_PINIT;
                end
                else
                    cmd.d_shift = 1'b1;
            end
            S_SQ:
            begin
                if (sts.s_le1)
                begin
                    code_next  = REJ_STRONG;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_ACC_ACC;
                    cmd.s_dec     = 1'b1;
                    state_next    = S_SQW;
                end
            end
            S_SQW:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.acc_from_r = 1'b1;
                    if (sts.r_nm1)
                    begin
                        code_next  = REJ_NONE;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SQ;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    op_next    = (code_reg == REJ_NONE);
                    oc_next    = code_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg   <= ph_next;
        code_reg <= code_next;
        op_reg   <= op_next;
        oc_reg   <= oc_next;
    end

endmodule

### rtl/core/probable_prime_tester.sv
// Top level of the probable prime tester (Miller-Rabin with Fermat checks).
// Joins ppt_ctrl and ppt_dp; depends on ppt_pkg.
//
// Usage:
//   Slave channel s_*: one beat carries a candidate and a witness base.
//   Master channel m_*: one result beat per input beat, in order.
//   Candidates 0 and 1 are rejected, 2 and 3 pass, even ones fail the
//   base-2 Fermat test at once. Odd candidates run Fermat bases 2 and 3,
//   reduce the witness modulo the candidate, then, unless it reduces to
//   zero, one strong round. Each modular product runs on the bit-serial
//   multiplier, which doubles and then adds for each multiplier bit (one
//   add and compare-subtract per cycle). Small and even candidates pass
//   through the check and output states; their result shows in the same
//   cycle that the input is free again.
//   Throughput: one candidate at a time; s_tready is high only when idle.
//   The result register parts the two sides: the next candidate is taken
//   while a finished result still waits on m_tready.
//   Stall: m_tvalid and m_tdata hold until m_tready; a second result then
//   waits in the controller until the register drains.
//   Reset: rst_n clears the controller and multiplier and drops m_tvalid;
//   the item in flight and any result waiting on m_tready are lost.
module probable_prime_tester
    import ppt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, lowest bit up: candidate, witness, zero pad to whole bytes
    input  logic [((2*WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, lowest bit up: is_probable_prime, rejected_by[2:0], zero pad
    output logic [7:0]                          m_tdata
);
    ppt_cmd_t   cmd;
    ppt_sts_t   sts;
    logic       prime;
    logic [2:0] code;

    ppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_prime (prime),
        .out_code  (code),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppt_dp #(.WIDTH(WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (s_tdata[WIDTH-1:0]),
        .witness   (s_tdata[2*WIDTH-1:WIDTH]),
        .cmd       (cmd),
        .sts       (sts)
    );

    // pack the result beat; upper bits stay zero
    assign m_tdata = {4'b0000, code, prime};

endmodule

### rtl/core/ppt_checker.sv
// Port-level checker for the probable prime tester, bound to the top level.
// Depends on probable_prime_tester's ports only.
module ppt_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= 3'd4))
        else $error("rejected_by out of range");

    a_prime_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'd0)))
        else $error("prime flag disagrees with code");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second candidate taken while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat dropped or changed under stall");

endmodule

bind probable_prime_tester ppt_port_checker u_ppt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/ppt_checker.sv
// Result checker for the probable prime tester: watches both stream channels,
// predicts each verdict and compares it with the result beats in order.
// Depends on ppt_pkg for the rejection codes.
module ppt_checker
    import ppt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending,
    output int          verdicts_seen,
    output int          composites_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       prime;
        logic [2:0] code;
    } verdict_t;

    verdict_t verdict_q[$];

    function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                                longint unsigned n);
        return (x * y) % n;
    endfunction

    function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                                longint unsigned n);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % n;
        sq  = b % n;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, sq, n);
            sq = mod_mul(sq, sq, n);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // One Miller-Rabin round; n is odd and at least five
    function automatic bit strong_round_passes(longint unsigned n, longint unsigned w);
        longint unsigned a;
        longint unsigned d;
        longint unsigned x;
        int unsigned     s;
        a = w % n;
        d = n - 1;
        s = 0;
        if (a == 0)
            return 1'b1;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 1 || x == n - 1)
            return 1'b1;
        for (int unsigned i = 1; i < s; i++)
        begin
            x = mod_mul(x, x, n);
            if (x == n - 1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic verdict_t primality_verdict(logic [31:0] cand, logic [31:0] wit);
        longint unsigned n;
        verdict_t v;
        n = cand;
        v.prime = 1'b0;
        if (n < 2)
            v.code = REJ_LOW;
        else if (n == 2 || n == 3)
        begin
            v.prime = 1'b1;
            v.code  = REJ_NONE;
        end
        else if (mod_pow(2, n - 1, n) != 1)
            v.code = REJ_FERMAT2;
        else if (mod_pow(3, n - 1, n) != 1)
            v.code = REJ_FERMAT3;
        else if (!strong_round_passes(n, longint'(wit)))
            v.code = REJ_STRONG;
        else
        begin
            v.prime = 1'b1;
            v.code  = REJ_NONE;
        end
        return v;
    endfunction

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            fail_count      <= 0;
            verdicts_seen   <= 0;
            composites_seen <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(primality_verdict(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                verdicts_seen <= verdicts_seen + 1;
                if (!m_tdata[0])
                    composites_seen <= composites_seen + 1;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: prime %0b code %0d",
                             $time, m_tdata[0], m_tdata[3:1]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.prime || m_tdata[3:1] !== want.code)
                    begin
                        $display("%0t: mismatch expected prime %0b code %0d, got prime %0b code %0d",
                                 $time, want.prime, want.code, m_tdata[0], m_tdata[3:1]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb_probable_prime_tester.sv
// Testbench top for the probable prime tester: drives candidate/witness beats
// and random back-pressure, and reports the verdict of ppt_checker.
// Depends on ppt_pkg, probable_prime_tester and ppt_checker.
module tb_probable_prime_tester;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int RANDOM_BEATS = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int fail_count;
    int pending;
    int verdicts_seen;
    int composites_seen;
    int cycles = 0;
    int beats_sent = 0;
    int stall_left = 0;
    bit steady_sink = 1'b0;

    // Known primes, including the largest below 2^32
    longint unsigned prime_pool[8] = '{5, 7, 65537, 1000000007, 2147483647,
                                       4294967291, 3221225473, 4294967279};
    // Carmichael numbers and strong pseudoprimes: pass Fermat, may fail the strong round
    longint unsigned pseudo_pool[8] = '{1105, 1729, 2465, 2821, 6601, 8911,
                                        25326001, 3215031751};

    always #5 clk = ~clk;

    probable_prime_tester #(.WIDTH(32)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // lowest bit up: candidate, witness
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // lowest bit up: is_probable_prime, rejected_by[2:0], pad
        .m_tdata  (m_tdata)
    );

    ppt_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .verdicts_seen   (verdicts_seen),
        .composites_seen (composites_seen)
    );

    // Watchdog: abandon the run if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sink back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_sink)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (pick < 25)
                stall_left <= $urandom_range(1, 3);
            else if (pick < 29)
                stall_left <= $urandom_range(40, 200);
        end
    end

    // Hold one beat until accepted, then, if gaps is set, sometimes leave a random gap
    task automatic send_candidate(input logic [31:0] cand, input logic [31:0] wit,
                                  input bit gaps);
        int pick;
        pick = $urandom_range(0, 99);
        s_tvalid <= 1'b1;
        s_tdata  <= {wit, cand};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        if (gaps && pick < 40)
        begin
            s_tvalid <= 1'b0;
            repeat ((pick < 5) ? $urandom_range(30, 150) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // Witness picker: mostly random, sometimes the trivial bases 0, 1, n-1 and n
    function automatic logic [31:0] pick_witness(longint unsigned n);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'(n - 1);
            3: return 32'(n);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int pick;
        logic [31:0] cand;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: below two, tiny primes, even numbers, trivial witnesses,
        // Fermat and strong pseudoprimes, extremes of both fields
        send_candidate(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_candidate(32'd1, 32'd0, 1'b0);
        send_candidate(32'd2, 32'd5, 1'b0);
        send_candidate(32'd3, 32'd0, 1'b0);
        send_candidate(32'd4, 32'd3, 1'b0);
        send_candidate(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        send_candidate(32'd5, 32'd0, 1'b0);
        send_candidate(32'd5, 32'd1, 1'b0);
        send_candidate(32'd5, 32'd4, 1'b0);
        send_candidate(32'd5, 32'd10, 1'b0);
        send_candidate(32'd9, 32'd2, 1'b0);
        send_candidate(32'd341, 32'd2, 1'b0);
        send_candidate(32'd2047, 32'd2, 1'b0);
        send_candidate(32'd1105, 32'd2, 1'b0);
        send_candidate(32'd1729, 32'd5, 1'b0);
        send_candidate(32'd25326001, 32'd2, 1'b0);
        send_candidate(32'd25326001, 32'd7, 1'b0);
        send_candidate(32'd3215031751, 32'd11, 1'b0);
        send_candidate(32'd4294967291, 32'hFFFF_FFFF, 1'b0);
        send_candidate(32'd2147483647, 32'd2, 1'b0);
        send_candidate(32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
        send_candidate(32'd65537, 32'hAAAA_AAAA, 1'b0);

        // Drain completely before the random part
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            pick = $urandom_range(0, 99);
            steady_sink = (i >= 40 && i < 55);
            if (i == 60)
            begin
                // Hold off until every verdict is back
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (pick < 30)
                cand = 32'(prime_pool[$urandom_range(0, 7)]);
            else if (pick < 55)
                cand = 32'(pseudo_pool[$urandom_range(0, 7)]);
            else if (pick < 70)
                cand = $urandom_range(0, 1000);
            else
                cand = $urandom | 32'(pick < 90);
            send_candidate(cand, pick_witness(cand), i < 40 || i >= 55);
        end
        s_tvalid <= 1'b0;
        steady_sink = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d candidate beats, %0d verdicts of which %0d composite or below two.",
                 beats_sent, verdicts_seen, composites_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
